// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the fault supervisor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, pre, post)
`define ASSERT_NEXT(label, pre, post)
`endif
`endif

// ----- hw/rtl/fs_pkg.sv -----
// Types and constants of the fault supervisor.
package fs_pkg;

  localparam int NumFaults  = 4;
  localparam int ChanW      = 2;
  localparam int DetW       = 4;
  localparam int KindW      = 3;
  localparam int TickWidth  = 16;
  localparam int CountWidth = 16;
  localparam int ChanCntW   = 3;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;
  localparam int QDepth     = 2;
  localparam int QCntW      = 2;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  // item kinds
  localparam logic [KindW-1:0] KindPoll     = 3'd0;
  localparam logic [KindW-1:0] KindTick     = 3'd1;
  localparam logic [KindW-1:0] KindClear    = 3'd2;
  localparam logic [KindW-1:0] KindClrHist  = 3'd3;
  localparam logic [KindW-1:0] KindClrAll   = 3'd4;

  // channel modes
  localparam logic [1:0] ModeIdle       = 2'd0;
  localparam logic [1:0] ModeActive     = 2'd1;
  localparam logic [1:0] ModeRecovering = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgChannelCount = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRecovery0    = 3'd1;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [DetW-1:0]  detect_bits;
    logic [ChanW-1:0] channel;
  } fs_in_t;

  typedef struct packed {
    logic [DetW-1:0]  active_flags;
    logic [DetW-1:0]  history_flags;
    logic [DetW-1:0]  fault_events;
    logic [DetW-1:0]  recover_events;
    logic             clear_refused;
    logic             any_active;
    logic             any_history;
    logic [1:0]       channel_status;
    logic [15:0]      channel_triggers;
  } fs_out_t;

  // classified item, as queued between front and back
  typedef struct packed {
    logic             poll;
    logic             tick;
    logic             clr;
    logic             clr_hist;
    logic             clr_all;
    logic [DetW-1:0]  detect_bits;
    logic [ChanW-1:0] channel;
  } fs_cmd_t;

  typedef struct packed {
    logic [NumFaults-1:0]                live_mask;
    logic [NumFaults-1:0][TickWidth-1:0] recovery_ticks;
  } fs_cfg_t;

endpackage

// ----- hw/rtl/fs_front.sv -----
// Front end: accepts items, classifies the kind, queues the commands.
`include "assert_macros.svh"

module fs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  fs_pkg::fs_in_t in_data_i,
  output logic           cmd_valid_o,
  output fs_pkg::fs_cmd_t cmd_o,
  input  logic           cmd_pop_i
);

  fs_pkg::fs_cmd_t                 q_mem_q [fs_pkg::QDepth];
  logic                            wr_ptr_q, wr_ptr_d;
  logic                            rd_ptr_q, rd_ptr_d;
  logic [fs_pkg::QCntW-1:0]        q_cnt_q, q_cnt_d;
  logic                            push, pop;
  fs_pkg::fs_cmd_t                 cmd_new;

  always_comb begin
    cmd_new             = '0;
    cmd_new.detect_bits = in_data_i.detect_bits;
    cmd_new.channel     = in_data_i.channel;
    case (in_data_i.kind)
      fs_pkg::KindPoll:    cmd_new.poll     = 1'b1;
      fs_pkg::KindTick:    cmd_new.tick     = 1'b1;
      fs_pkg::KindClear:   cmd_new.clr      = 1'b1;
      fs_pkg::KindClrHist: cmd_new.clr_hist = 1'b1;
      fs_pkg::KindClrAll:  cmd_new.clr_all  = 1'b1;
      default:             cmd_new.poll     = 1'b0; // unknown kind: readback only
    endcase
  end

  assign in_stall_o  = (q_cnt_q == fs_pkg::QCntW'(fs_pkg::QDepth));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (q_cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    q_cnt_d  = q_cnt_q;
    if (push && !pop) begin
      q_cnt_d = q_cnt_q + 2'd1;
    end else if (pop && !push) begin
      q_cnt_d = q_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      q_cnt_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      q_cnt_q  <= q_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  `ASSERT_IMPLY(a_q_cnt_bound, 1'b1, q_cnt_q <= fs_pkg::QCntW'(fs_pkg::QDepth))
  `ASSERT_NEXT(a_q_push_grows, push && !pop, q_cnt_q == $past(q_cnt_q) + 2'd1)
  `ASSERT_NEXT(a_q_pop_shrinks, pop && !push, q_cnt_q == $past(q_cnt_q) - 2'd1)

endmodule

// ----- hw/rtl/fs_back.sv -----
// Back end: channel state, command execution and result register.
`include "assert_macros.svh"

module fs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fs_pkg::fs_cfg_t cfg_i,
  input  logic            cmd_valid_i,
  input  fs_pkg::fs_cmd_t cmd_i,
  output logic            cmd_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output fs_pkg::fs_out_t out_data_o
);

  logic [fs_pkg::NumFaults-1:0][1:0]                     mode_q, mode_d;
  logic [fs_pkg::NumFaults-1:0][fs_pkg::TickWidth-1:0]   cool_q, cool_d;
  logic [fs_pkg::NumFaults-1:0][fs_pkg::CountWidth-1:0]  trig_q, trig_d;
  logic [fs_pkg::NumFaults-1:0]                          hist_q, hist_d;
  logic [fs_pkg::NumFaults-1:0]                          act_d;
  logic [fs_pkg::NumFaults-1:0]                          fault_ev, recover_ev;
  logic                                                  refused;
  logic                                                  out_valid_q;
  fs_pkg::fs_out_t                                       out_q, out_d;
  logic                                                  pop;

  assign pop       = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o = pop;

  always_comb begin
    mode_d     = mode_q;
    cool_d     = cool_q;
    trig_d     = trig_q;
    hist_d     = hist_q;
    fault_ev   = '0;
    recover_ev = '0;
    refused    = 1'b0;
    for (int i = 0; i < fs_pkg::NumFaults; i++) begin
      if (cfg_i.live_mask[i]) begin
        if (cmd_i.poll) begin
          case (mode_q[i])
            fs_pkg::ModeIdle: begin
              if (cmd_i.detect_bits[i]) begin
                if (trig_q[i] != fs_pkg::CountMax) begin
                  trig_d[i] = trig_q[i] + 1'b1;
                end
                hist_d[i]   = 1'b1;
                fault_ev[i] = 1'b1;
                if (cfg_i.recovery_ticks[i] != '0) begin
                  cool_d[i] = cfg_i.recovery_ticks[i];
                  mode_d[i] = fs_pkg::ModeRecovering;
                end else begin
                  mode_d[i] = fs_pkg::ModeActive;
                end
              end
            end
            fs_pkg::ModeRecovering: begin
              if (cool_q[i] == '0) begin
                if (cmd_i.detect_bits[i]) begin
                  cool_d[i] = cfg_i.recovery_ticks[i];
                end else begin
                  mode_d[i]     = fs_pkg::ModeIdle;
                  recover_ev[i] = 1'b1;
                end
              end
            end
            default: mode_d[i] = mode_q[i];
          endcase
        end
        if (cmd_i.tick && mode_q[i] == fs_pkg::ModeRecovering && cool_q[i] != '0) begin
          cool_d[i] = cool_q[i] - 1'b1;
        end
        if (cmd_i.clr && cmd_i.channel == fs_pkg::ChanW'(i)
            && mode_q[i] == fs_pkg::ModeActive) begin
          if (!cmd_i.detect_bits[i]) begin
            mode_d[i]     = fs_pkg::ModeIdle;
            recover_ev[i] = 1'b1;
          end else begin
            refused = 1'b1;
          end
        end
        if (cmd_i.clr_hist && cmd_i.channel == fs_pkg::ChanW'(i)) begin
          hist_d[i] = 1'b0;
        end
      end
    end
    if (cmd_i.clr_all) begin
      hist_d = '0;
    end
    for (int i = 0; i < fs_pkg::NumFaults; i++) begin
      act_d[i] = (mode_d[i] != fs_pkg::ModeIdle);
    end
  end

  always_comb begin
    out_d                  = '0;
    out_d.active_flags     = act_d;
    out_d.history_flags    = hist_d;
    out_d.fault_events     = fault_ev;
    out_d.recover_events   = recover_ev;
    out_d.clear_refused    = refused;
    out_d.any_active       = |act_d;
    out_d.any_history      = |hist_d;
    out_d.channel_status   = mode_d[cmd_i.channel];
    out_d.channel_triggers = trig_d[cmd_i.channel][15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= '0;
      cool_q      <= '0;
      trig_q      <= '0;
      hist_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        mode_q <= mode_d;
        cool_q <= cool_d;
        trig_q <= trig_d;
        hist_q <= hist_d;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPLY(a_fault_only_on_poll, pop && !cmd_i.poll, fault_ev == '0)
  `ASSERT_IMPLY(a_events_disjoint, pop, (fault_ev & recover_ev) == '0)
  `ASSERT_IMPLY(a_refuse_only_on_clear, pop && refused, cmd_i.clr && recover_ev == '0)

endmodule

// ----- hw/rtl/fault_supervisor.sv -----
// Top level of the fault supervisor: config registers, front end, back end.
//
// Usage:
//   Items enter on in_valid_i/in_data_i (kind, detect_bits, channel) and are
//   taken on a clock edge with in_valid_i high and in_stall_o low. Each item
//   yields exactly one result on out_valid_o/out_data_o, transferred on an
//   edge with out_valid_o high and out_stall_i low.
//   Path: a taken item is written into the command queue; the back end then
//   moves it into the result register when that register is empty or drains.
//   Throughput: one item per cycle while in_stall_o is low. Poll and tick
//   items update all live channels in parallel; Clear and ClrHist items only the addressed one.
//   Receiver stall: the result register holds, the two-entry command queue
//   absorbs up to two more items, then in_stall_o goes high.
//   Config: cfg_valid_i/cfg_index_i/cfg_data_i; cfg_ready_o is always high.
//   Index 0 is channel_count, 1..4 are recovery_ticks of channels 0..3.
//   Write config only while no item is in flight.
//   Reset: all channels idle, counts and masks zero, config zero, queue empty.
`include "assert_macros.svh"

module fault_supervisor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  fs_pkg::fs_in_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fs_pkg::fs_out_t             out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fs_pkg::CfgDataW-1:0] cfg_data_i
);

  // config registers
  logic [fs_pkg::ChanCntW-1:0]                          chan_cnt_q;
  logic [fs_pkg::NumFaults-1:0][fs_pkg::TickWidth-1:0]  ticks_q;
  fs_pkg::fs_cfg_t                                      cfg;
  logic                                                 cfg_wr;

  // front/back link
  logic            cmd_valid;
  logic            cmd_pop;
  fs_pkg::fs_cmd_t cmd;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= '0;
      ticks_q    <= '0;
    end else if (cfg_wr) begin
      if (cfg_index_i == fs_pkg::CfgChannelCount) begin
        chan_cnt_q <= cfg_data_i[fs_pkg::ChanCntW-1:0];
      end
      for (int i = 0; i < fs_pkg::NumFaults; i++) begin
        if (cfg_index_i == fs_pkg::CfgRecovery0 + fs_pkg::CfgIdxW'(i)) begin
          ticks_q[i] <= cfg_data_i[fs_pkg::TickWidth-1:0];
        end
      end
    end
  end

  // A count above the channel total simply enables every channel.
  always_comb begin
    cfg.recovery_ticks = ticks_q;
    for (int i = 0; i < fs_pkg::NumFaults; i++) begin
      cfg.live_mask[i] = (chan_cnt_q > fs_pkg::ChanCntW'(i));
    end
  end

  fs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  fs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // status summaries must agree with the masks they summarize
  `ASSERT_IMPLY(a_any_active, out_valid_o, out_data_o.any_active == |out_data_o.active_flags)
  `ASSERT_IMPLY(a_any_hist, out_valid_o, out_data_o.any_history == |out_data_o.history_flags)
  `ASSERT_IMPLY(a_pop_needs_cmd, cmd_pop, cmd_valid)

endmodule
